// ===== rtl/mrp_pkg.sv =====
// Shared types, constants, micro-op codes and geometry helpers for the
// maxrects best-area-fit packer. Depends on nothing; every file but mrp_ram imports it.
`timescale 1ns / 1ps
`default_nettype none
package mrp_pkg;

   localparam int FREE_CAPACITY = 64;
   localparam int COORD_BITS    = 13;
   localparam int IDX_W         = $clog2(FREE_CAPACITY);
   localparam int CNT_W         = $clog2(FREE_CAPACITY + 1);
   localparam int POS_W         = COORD_BITS - 1;
   localparam int SUM_W         = COORD_BITS + 1;
   localparam int PROD_W        = 2 * COORD_BITS;
   localparam int BOX_W         = 4 * COORD_BITS;
   localparam int CSR_IDX_W     = 1;
   localparam logic [COORD_BITS-1:0] BIN_MAX = COORD_BITS'(1) << (COORD_BITS - 1);

   localparam logic [CSR_IDX_W-1:0] REG_BIN_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BIN_HEIGHT = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type w;
      coord_type h;
   } box_type;

   typedef logic [4:0] op_type;

   localparam op_type OP_NONE        = 5'd0;
   localparam op_type OP_INIT        = 5'd1;
   localparam op_type OP_ACCEPT      = 5'd2;
   localparam op_type OP_RD_FI       = 5'd3;
   localparam op_type OP_LATCH_F     = 5'd4;
   localparam op_type OP_SCMP        = 5'd5;
   localparam op_type OP_CLR_I       = 5'd6;
   localparam op_type OP_INC_I       = 5'd7;
   localparam op_type OP_START_CUT   = 5'd8;
   localparam op_type OP_LATCH_PIECE = 5'd9;
   localparam op_type OP_SEL_INC     = 5'd10;
   localparam op_type OP_RD_NJ       = 5'd11;
   localparam op_type OP_DEC_MARK    = 5'd12;
   localparam op_type OP_INC_J       = 5'd13;
   localparam op_type OP_RD_NMARK    = 5'd14;
   localparam op_type OP_SW_J        = 5'd15;
   localparam op_type OP_SW_MARK     = 5'd16;
   localparam op_type OP_APPEND      = 5'd17;
   localparam op_type OP_RD_FLAST    = 5'd18;
   localparam op_type OP_RM_WR       = 5'd19;
   localparam op_type OP_LATCH_PF    = 5'd20;
   localparam op_type OP_RD_NLAST    = 5'd21;
   localparam op_type OP_PRN_MV      = 5'd22;
   localparam op_type OP_CLR_J       = 5'd23;
   localparam op_type OP_DROP        = 5'd24;
   localparam op_type OP_MRG_WR      = 5'd25;
   localparam op_type OP_DONE        = 5'd26;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic i_lt_free;
      logic j_lt_mark;
      logic j_lt_new;
      logic free_full;
      logic found;
      logic overlap;
      logic piece_hit;
      logic sel_last;
      logic piece_in_old;
      logic old_in_piece;
      logic prune_hit;
      logic rsp_free;
   } status_type;

   // True when box a lies wholly inside box b
   function automatic logic lies_in(input box_type a, input box_type b);
      logic [SUM_W-1:0] ax2, ay2, bx2, by2;
      ax2 = SUM_W'(a.x) + SUM_W'(a.w);
      ay2 = SUM_W'(a.y) + SUM_W'(a.h);
      bx2 = SUM_W'(b.x) + SUM_W'(b.w);
      by2 = SUM_W'(b.y) + SUM_W'(b.h);
      return (a.x >= b.x) && (a.y >= b.y) && (ax2 <= bx2) && (ay2 <= by2);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/mrp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/mrp_datapath.sv =====
// Datapath of the packer: free and piece RAMs, counters, best-fit search,
// split and containment logic, result register. Uses mrp_pkg and mrp_ram.
`timescale 1ns / 1ps
`default_nettype none
module mrp_datapath import mrp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [COORD_BITS-1:0] req_width,
   input  wire logic [COORD_BITS-1:0] req_height,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [COORD_BITS-1:0] csr_wdata,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [POS_W-1:0]      rsp_pos_x,
   output logic      [POS_W-1:0]      rsp_pos_y,
   output logic      [COORD_BITS-1:0] rsp_placed_width,
   output logic      [COORD_BITS-1:0] rsp_placed_height,
   output logic                       rsp_rotated,
   output logic                       rsp_placed,
   output logic                       rsp_table_overflow
);

   coord_type bin_w_ff, bin_w_in, bin_h_ff, bin_h_in;
   coord_type req_w_ff, req_w_in, req_h_ff, req_h_in;
   logic req_ok_ff, req_ok_in, found_ff, found_in, rot_ff, rot_in, drop_ff, drop_in;
   box_type best_ff, best_in, cur_f_ff, cur_f_in, piece_ff, piece_in, prune_f_ff, prune_f_in;
   logic [PROD_W-1:0] best_prod_ff, best_prod_in, prod_ff, prod_in;
   coord_type best_side_ff, best_side_in;
   logic [CNT_W-1:0] free_cnt_ff, free_cnt_in, new_cnt_ff, new_cnt_in;
   logic [CNT_W-1:0] mark_ff, mark_in, i_ff, i_in, j_ff, j_in;
   logic [1:0] sel_ff, sel_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_rot_ff, rsp_rot_in;
   logic rsp_placed_ff, rsp_placed_in, rsp_ovf_ff, rsp_ovf_in;
   box_type rsp_box_ff, rsp_box_in;

   logic f_we, n_we;
   logic [IDX_W-1:0] f_waddr, f_raddr, n_waddr, n_raddr;
   box_type f_wdata, n_wdata;
   logic [BOX_W-1:0] f_rd_raw, n_rd_raw;
   box_type f_rd, n_rd;

   assign f_rd = box_type'(f_rd_raw);
   assign n_rd = box_type'(n_rd_raw);

   mrp_ram #(.WIDTH(BOX_W), .DEPTH(FREE_CAPACITY)) u_free_ram (
      .clock(clock), .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
      .rd_addr(f_raddr), .rd_data(f_rd_raw)
   );

   mrp_ram #(.WIDTH(BOX_W), .DEPTH(FREE_CAPACITY)) u_piece_ram (
      .clock(clock), .wr_en(n_we), .wr_addr(n_waddr), .wr_data(n_wdata),
      .rd_addr(n_raddr), .rd_data(n_rd_raw)
   );

   // Best-fit scoring of the held free rectangle
   logic fit_u, fit_r, better_u, better_r, found_1;
   coord_type side_u, side_r, side_1, du_w, du_h, dr_w, dr_h;
   logic [PROD_W-1:0] prod_1;

   always_comb begin
      fit_u    = req_ok_ff && (cur_f_ff.w >= req_w_ff) && (cur_f_ff.h >= req_h_ff);
      fit_r    = req_ok_ff && (cur_f_ff.w >= req_h_ff) && (cur_f_ff.h >= req_w_ff);
      du_w     = cur_f_ff.w - req_w_ff;
      du_h     = cur_f_ff.h - req_h_ff;
      dr_w     = cur_f_ff.w - req_h_ff;
      dr_h     = cur_f_ff.h - req_w_ff;
      side_u   = (du_w < du_h) ? du_w : du_h;
      side_r   = (dr_w < dr_h) ? dr_w : dr_h;
      better_u = fit_u && (!found_ff || (prod_ff < best_prod_ff) ||
                 ((prod_ff == best_prod_ff) && (side_u < best_side_ff)));
      found_1  = found_ff || fit_u;
      prod_1   = better_u ? prod_ff : best_prod_ff;
      side_1   = better_u ? side_u : best_side_ff;
      better_r = fit_r && (!found_1 || (prod_ff < prod_1) ||
                 ((prod_ff == prod_1) && (side_r < side_1)));
   end

   // Overlap test and maximal pieces of the held free rectangle around the placement
   logic [SUM_W-1:0] fx0, fy0, fx2, fy2, ux0, uy0, ux2, uy2;
   logic overlap, piece_hit;
   box_type piece_new;

   always_comb begin
      fx0 = SUM_W'(cur_f_ff.x);
      fy0 = SUM_W'(cur_f_ff.y);
      fx2 = fx0 + SUM_W'(cur_f_ff.w);
      fy2 = fy0 + SUM_W'(cur_f_ff.h);
      ux0 = SUM_W'(best_ff.x);
      uy0 = SUM_W'(best_ff.y);
      ux2 = ux0 + SUM_W'(best_ff.w);
      uy2 = uy0 + SUM_W'(best_ff.h);
      overlap = !((ux0 >= fx2) || (ux2 <= fx0) || (uy0 >= fy2) || (uy2 <= fy0));
      piece_new = cur_f_ff;
      case (sel_ff)
         2'd0: begin
            piece_hit   = (uy0 > fy0) && (uy0 < fy2);
            piece_new.h = COORD_BITS'(uy0 - fy0);
         end
         2'd1: begin
            piece_hit   = uy2 < fy2;
            piece_new.y = COORD_BITS'(uy2);
            piece_new.h = COORD_BITS'(fy2 - uy2);
         end
         2'd2: begin
            piece_hit   = (ux0 > fx0) && (ux0 < fx2);
            piece_new.w = COORD_BITS'(ux0 - fx0);
         end
         default: begin
            piece_hit   = ux2 < fx2;
            piece_new.x = COORD_BITS'(ux2);
            piece_new.w = COORD_BITS'(fx2 - ux2);
         end
      endcase
   end

   logic [CNT_W-1:0] free_last, new_last;
   coord_type csr_clamped;

   always_comb begin
      free_last   = free_cnt_ff - CNT_W'(1);
      new_last    = new_cnt_ff - CNT_W'(1);
      csr_clamped = (csr_wdata > BIN_MAX) ? BIN_MAX : csr_wdata;

      bin_w_in      = bin_w_ff;
      bin_h_in      = bin_h_ff;
      req_w_in      = req_w_ff;
      req_h_in      = req_h_ff;
      req_ok_in     = req_ok_ff;
      found_in      = found_ff;
      rot_in        = rot_ff;
      drop_in       = drop_ff;
      best_in       = best_ff;
      cur_f_in      = cur_f_ff;
      piece_in      = piece_ff;
      prune_f_in    = prune_f_ff;
      best_prod_in  = best_prod_ff;
      best_side_in  = best_side_ff;
      prod_in       = prod_ff;
      free_cnt_in   = free_cnt_ff;
      new_cnt_in    = new_cnt_ff;
      mark_in       = mark_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      sel_in        = sel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_rot_in    = rsp_rot_ff;
      rsp_placed_in = rsp_placed_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_box_in    = rsp_box_ff;

      f_we    = 1'b0;
      f_waddr = i_ff[IDX_W-1:0];
      f_wdata = f_rd;
      f_raddr = i_ff[IDX_W-1:0];
      n_we    = 1'b0;
      n_waddr = j_ff[IDX_W-1:0];
      n_wdata = n_rd;
      n_raddr = j_ff[IDX_W-1:0];

      case (cmd.op)
         OP_INIT: begin
            f_we    = 1'b1;
            f_waddr = '0;
            f_wdata = '{x: '0, y: '0, w: bin_w_ff, h: bin_h_ff};
         end
         OP_ACCEPT: begin
            req_w_in  = req_width;
            req_h_in  = req_height;
            req_ok_in = (req_width != '0) && (req_height != '0);
            found_in  = 1'b0;
            rot_in    = 1'b0;
            drop_in   = 1'b0;
            i_in      = '0;
         end
         OP_RD_FI: f_raddr = i_ff[IDX_W-1:0];
         OP_LATCH_F: begin
            cur_f_in = f_rd;
            prod_in  = PROD_W'(f_rd.w) * PROD_W'(f_rd.h);
         end
         OP_SCMP: begin
            if (better_r) begin
               best_in      = '{x: cur_f_ff.x, y: cur_f_ff.y, w: req_h_ff, h: req_w_ff};
               rot_in       = 1'b1;
               best_prod_in = prod_ff;
               best_side_in = side_r;
               found_in     = 1'b1;
            end else if (better_u) begin
               best_in      = '{x: cur_f_ff.x, y: cur_f_ff.y, w: req_w_ff, h: req_h_ff};
               rot_in       = 1'b0;
               best_prod_in = prod_ff;
               best_side_in = side_u;
               found_in     = 1'b1;
            end
            i_in = i_ff + CNT_W'(1);
         end
         OP_CLR_I: i_in = '0;
         OP_INC_I: i_in = i_ff + CNT_W'(1);
         OP_START_CUT: begin
            mark_in = new_cnt_ff;
            sel_in  = 2'd0;
         end
         OP_LATCH_PIECE: begin
            piece_in = piece_new;
            j_in     = '0;
         end
         OP_SEL_INC: sel_in = sel_ff + 2'd1;
         OP_RD_NJ: n_raddr = j_ff[IDX_W-1:0];
         OP_DEC_MARK: mark_in = mark_ff - CNT_W'(1);
         OP_INC_J: j_in = j_ff + CNT_W'(1);
         OP_RD_NMARK: n_raddr = mark_ff[IDX_W-1:0];
         OP_SW_J: begin
            n_we    = 1'b1;
            n_waddr = j_ff[IDX_W-1:0];
            n_wdata = n_rd;
            n_raddr = new_last[IDX_W-1:0];
         end
         OP_SW_MARK: begin
            n_we       = 1'b1;
            n_waddr    = mark_ff[IDX_W-1:0];
            n_wdata    = n_rd;
            new_cnt_in = new_last;
         end
         OP_APPEND: begin
            if (new_cnt_ff >= CNT_W'(FREE_CAPACITY)) begin
               drop_in = 1'b1;
            end else begin
               n_we       = 1'b1;
               n_waddr    = new_cnt_ff[IDX_W-1:0];
               n_wdata    = piece_ff;
               new_cnt_in = new_cnt_ff + CNT_W'(1);
            end
         end
         OP_RD_FLAST: f_raddr = free_last[IDX_W-1:0];
         OP_RM_WR: begin
            f_we        = 1'b1;
            f_waddr     = i_ff[IDX_W-1:0];
            f_wdata     = f_rd;
            free_cnt_in = free_last;
         end
         OP_LATCH_PF: begin
            prune_f_in = f_rd;
            j_in       = '0;
         end
         OP_RD_NLAST: n_raddr = new_last[IDX_W-1:0];
         OP_PRN_MV: begin
            n_we       = 1'b1;
            n_waddr    = j_ff[IDX_W-1:0];
            n_wdata    = n_rd;
            new_cnt_in = new_last;
         end
         OP_CLR_J: j_in = '0;
         OP_DROP: drop_in = 1'b1;
         OP_MRG_WR: begin
            f_we        = 1'b1;
            f_waddr     = free_cnt_ff[IDX_W-1:0];
            f_wdata     = n_rd;
            free_cnt_in = free_cnt_ff + CNT_W'(1);
            j_in        = j_ff + CNT_W'(1);
         end
         OP_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_placed_in = found_ff;
            rsp_rot_in    = found_ff && rot_ff;
            rsp_ovf_in    = found_ff && drop_ff;
            rsp_box_in    = found_ff ? best_ff : '0;
            new_cnt_in    = '0;
         end
         default: ;
      endcase

      // Bin size write: reload the free list with the whole bin
      if (csr_write_enable) begin
         if (csr_index == REG_BIN_WIDTH) begin
            bin_w_in = csr_clamped;
         end else begin
            bin_h_in = csr_clamped;
         end
         f_we        = 1'b1;
         f_waddr     = '0;
         f_wdata     = '{x: '0, y: '0, w: bin_w_in, h: bin_h_in};
         free_cnt_in = CNT_W'(1);
         new_cnt_in  = '0;
         mark_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_w_ff     <= BIN_MAX;
         bin_h_ff     <= BIN_MAX;
         free_cnt_ff  <= CNT_W'(1);
         new_cnt_ff   <= '0;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bin_w_ff     <= bin_w_in;
         bin_h_ff     <= bin_h_in;
         free_cnt_ff  <= free_cnt_in;
         new_cnt_ff   <= new_cnt_in;
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_w_ff      <= req_w_in;
      req_h_ff      <= req_h_in;
      req_ok_ff     <= req_ok_in;
      found_ff      <= found_in;
      rot_ff        <= rot_in;
      drop_ff       <= drop_in;
      best_ff       <= best_in;
      cur_f_ff      <= cur_f_in;
      piece_ff      <= piece_in;
      prune_f_ff    <= prune_f_in;
      best_prod_ff  <= best_prod_in;
      best_side_ff  <= best_side_in;
      prod_ff       <= prod_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      sel_ff        <= sel_in;
      rsp_rot_ff    <= rsp_rot_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_box_ff    <= rsp_box_in;
   end

   always_comb begin
      status.i_lt_free    = i_ff < free_cnt_ff;
      status.j_lt_mark    = j_ff < mark_ff;
      status.j_lt_new     = j_ff < new_cnt_ff;
      status.free_full    = free_cnt_ff >= CNT_W'(FREE_CAPACITY);
      status.found        = found_ff;
      status.overlap      = overlap;
      status.piece_hit    = piece_hit;
      status.sel_last     = sel_ff == 2'd3;
      status.piece_in_old = lies_in(piece_ff, n_rd);
      status.old_in_piece = lies_in(n_rd, piece_ff);
      status.prune_hit    = lies_in(n_rd, prune_f_ff);
      status.rsp_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pos_x          = rsp_box_ff.x[POS_W-1:0];
   assign rsp_pos_y          = rsp_box_ff.y[POS_W-1:0];
   assign rsp_placed_width   = rsp_box_ff.w;
   assign rsp_placed_height  = rsp_box_ff.h;
   assign rsp_rotated        = rsp_rot_ff;
   assign rsp_placed         = rsp_placed_ff;
   assign rsp_table_overflow = rsp_ovf_ff;

endmodule
`default_nettype wire

// ===== rtl/mrp_controller.sv =====
// Sequencer of the packer: steps search, split, prune and merge one RAM
// access at a time. Uses mrp_pkg; drives mrp_datapath through cmd_type.
`timescale 1ns / 1ps
`default_nettype none
module mrp_controller import mrp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [4:0] S_INIT     = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_SRCH_RD  = 5'd2;
   localparam logic [4:0] S_SRCH_MUL = 5'd3;
   localparam logic [4:0] S_SRCH_CMP = 5'd4;
   localparam logic [4:0] S_SRCH_END = 5'd5;
   localparam logic [4:0] S_PLC_RD   = 5'd6;
   localparam logic [4:0] S_PLC_CHK  = 5'd7;
   localparam logic [4:0] S_PLC_OVL  = 5'd8;
   localparam logic [4:0] S_PIECE    = 5'd9;
   localparam logic [4:0] S_PNEXT    = 5'd10;
   localparam logic [4:0] S_ADD_RD   = 5'd11;
   localparam logic [4:0] S_ADD_CMP  = 5'd12;
   localparam logic [4:0] S_ADD_SW1  = 5'd13;
   localparam logic [4:0] S_ADD_SW2  = 5'd14;
   localparam logic [4:0] S_ADD_SW3  = 5'd15;
   localparam logic [4:0] S_ADD_APP  = 5'd16;
   localparam logic [4:0] S_RM_RD    = 5'd17;
   localparam logic [4:0] S_RM_WR    = 5'd18;
   localparam logic [4:0] S_PRN_I    = 5'd19;
   localparam logic [4:0] S_PRN_LF   = 5'd20;
   localparam logic [4:0] S_PRN_J    = 5'd21;
   localparam logic [4:0] S_PRN_CMP  = 5'd22;
   localparam logic [4:0] S_PRN_MV   = 5'd23;
   localparam logic [4:0] S_MRG_RD   = 5'd24;
   localparam logic [4:0] S_MRG_WR   = 5'd25;
   localparam logic [4:0] S_DONE     = 5'd26;

   logic [4:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.op   = OP_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            if (status.i_lt_free) begin
               cmd.op   = OP_RD_FI;
               state_in = S_SRCH_MUL;
            end else begin
               state_in = S_SRCH_END;
            end
         end
         S_SRCH_MUL: begin
            cmd.op   = OP_LATCH_F;
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            cmd.op   = OP_SCMP;
            state_in = S_SRCH_RD;
         end
         S_SRCH_END: begin
            if (status.found) begin
               cmd.op   = OP_CLR_I;
               state_in = S_PLC_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PLC_RD: begin
            if (status.i_lt_free) begin
               cmd.op   = OP_RD_FI;
               state_in = S_PLC_CHK;
            end else begin
               cmd.op   = OP_CLR_I;
               state_in = S_PRN_I;
            end
         end
         S_PLC_CHK: begin
            cmd.op   = OP_LATCH_F;
            state_in = S_PLC_OVL;
         end
         S_PLC_OVL: begin
            if (status.overlap) begin
               cmd.op   = OP_START_CUT;
               state_in = S_PIECE;
            end else begin
               cmd.op   = OP_INC_I;
               state_in = S_PLC_RD;
            end
         end
         S_PIECE: begin
            if (status.piece_hit) begin
               cmd.op   = OP_LATCH_PIECE;
               state_in = S_ADD_RD;
            end else if (status.sel_last) begin
               state_in = S_RM_RD;
            end else begin
               cmd.op   = OP_SEL_INC;
               state_in = S_PIECE;
            end
         end
         S_PNEXT: begin
            if (status.sel_last) begin
               state_in = S_RM_RD;
            end else begin
               cmd.op   = OP_SEL_INC;
               state_in = S_PIECE;
            end
         end
         S_ADD_RD: begin
            if (status.j_lt_mark) begin
               cmd.op   = OP_RD_NJ;
               state_in = S_ADD_CMP;
            end else begin
               state_in = S_ADD_APP;
            end
         end
         S_ADD_CMP: begin
            if (status.piece_in_old) begin
               state_in = S_PNEXT;
            end else if (status.old_in_piece) begin
               cmd.op   = OP_DEC_MARK;
               state_in = S_ADD_SW1;
            end else begin
               cmd.op   = OP_INC_J;
               state_in = S_ADD_RD;
            end
         end
         S_ADD_SW1: begin
            cmd.op   = OP_RD_NMARK;
            state_in = S_ADD_SW2;
         end
         S_ADD_SW2: begin
            cmd.op   = OP_SW_J;
            state_in = S_ADD_SW3;
         end
         S_ADD_SW3: begin
            cmd.op   = OP_SW_MARK;
            state_in = S_ADD_RD;
         end
         S_ADD_APP: begin
            cmd.op   = OP_APPEND;
            state_in = S_PNEXT;
         end
         S_RM_RD: begin
            cmd.op   = OP_RD_FLAST;
            state_in = S_RM_WR;
         end
         S_RM_WR: begin
            cmd.op   = OP_RM_WR;
            state_in = S_PLC_RD;
         end
         S_PRN_I: begin
            if (status.i_lt_free) begin
               cmd.op   = OP_RD_FI;
               state_in = S_PRN_LF;
            end else begin
               cmd.op   = OP_CLR_J;
               state_in = S_MRG_RD;
            end
         end
         S_PRN_LF: begin
            cmd.op   = OP_LATCH_PF;
            state_in = S_PRN_J;
         end
         S_PRN_J: begin
            if (status.j_lt_new) begin
               cmd.op   = OP_RD_NJ;
               state_in = S_PRN_CMP;
            end else begin
               cmd.op   = OP_INC_I;
               state_in = S_PRN_I;
            end
         end
         S_PRN_CMP: begin
            if (status.prune_hit) begin
               cmd.op   = OP_RD_NLAST;
               state_in = S_PRN_MV;
            end else begin
               cmd.op   = OP_INC_J;
               state_in = S_PRN_J;
            end
         end
         S_PRN_MV: begin
            cmd.op   = OP_PRN_MV;
            state_in = S_PRN_J;
         end
         S_MRG_RD: begin
            if (!status.j_lt_new) begin
               state_in = S_DONE;
            end else if (status.free_full) begin
               cmd.op   = OP_DROP;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_RD_NJ;
               state_in = S_MRG_WR;
            end
         end
         S_MRG_WR: begin
            cmd.op   = OP_MRG_WR;
            state_in = S_MRG_RD;
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.op   = OP_DONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/maxrects_best_area_fit_packer.sv =====
// Top level of the maxrects best-area-fit packer: joins mrp_controller and
// mrp_datapath. Uses mrp_pkg.
//
//  - Request channel (req_*): one beat carries a width and a height to place.
//  - Response channel (rsp_*): one beat per request with position, placed size,
//    rotation, placed and list-overflow flags. A zero side or no fit answers
//    placed = 0 with all other fields zero and leaves the free list untouched.
//  - CSR port: a write to bin_width (index 0) or bin_height (index 1) lands at
//    that edge, saturates above 4096 and reloads the free list with the whole
//    bin. Write only while the block is idle.
//  - Sequence: one request at a time. Search reads each free rectangle in turn;
//    placement reads each one again, and for each one cut tries up to 4 pieces,
//    each checked against pieces from earlier cuts (an earlier piece that the
//    new one covers is removed); pruning checks each (free rectangle, piece) pair
//    and merging copies each piece into the free list. Every step is paced by one
//    read port per list RAM.
//  - Reset: one cycle after reset loads the whole-bin rectangle (4096 x 4096)
//    into the free RAM; req_ready rises after it.
//  - Stall: a finished result waits in the output register while the next
//    request is accepted and worked on; hold in the final step if it is full.
`timescale 1ns / 1ps
`default_nettype none
module maxrects_best_area_fit_packer import mrp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [COORD_BITS-1:0] req_width,
   input  wire logic [COORD_BITS-1:0] req_height,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [POS_W-1:0]      rsp_pos_x,
   output logic      [POS_W-1:0]      rsp_pos_y,
   output logic      [COORD_BITS-1:0] rsp_placed_width,
   output logic      [COORD_BITS-1:0] rsp_placed_height,
   output logic                       rsp_rotated,
   output logic                       rsp_placed,
   output logic                       rsp_table_overflow,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [COORD_BITS-1:0] csr_wdata
);

   // Command and status travel as one bundle each way
   cmd_type    cmd;
   status_type status;

   // Sequencer: owns the handshake on the request side
   mrp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage, arithmetic and the response register
   mrp_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_width          (req_width),
      .req_height         (req_height),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_placed_width   (rsp_placed_width),
      .rsp_placed_height  (rsp_placed_height),
      .rsp_rotated        (rsp_rotated),
      .rsp_placed         (rsp_placed),
      .rsp_table_overflow (rsp_table_overflow)
   );

endmodule
`default_nettype wire

// ===== rtl/mrp_checker.sv =====
// Port-level checks on the packer, bound to the top level.
// Uses mrp_pkg; attaches to maxrects_best_area_fit_packer.
`timescale 1ns / 1ps
`default_nettype none
module mrp_checker import mrp_pkg::*; (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [POS_W-1:0]      rsp_pos_x,
   input wire logic [POS_W-1:0]      rsp_pos_y,
   input wire logic [COORD_BITS-1:0] rsp_placed_width,
   input wire logic [COORD_BITS-1:0] rsp_placed_height,
   input wire logic                  rsp_rotated,
   input wire logic                  rsp_placed,
   input wire logic                  rsp_table_overflow
);

   // A failed placement carries nothing but the flag
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_placed |-> rsp_pos_x == '0 && rsp_pos_y == '0 &&
      rsp_placed_width == '0 && rsp_placed_height == '0 &&
      !rsp_rotated && !rsp_table_overflow)
      else $error("failed placement with nonzero fields");

   // A placed rectangle never has an empty side
   a_placed_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_placed |-> rsp_placed_width != '0 && rsp_placed_height != '0)
      else $error("placed rectangle with empty side");

   // One request at a time: ready drops after each accepted beat
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A stalled response holds its valid, position and placed flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) &&
      $stable(rsp_pos_y) && $stable(rsp_placed))
      else $error("stalled response changed");

endmodule

bind maxrects_best_area_fit_packer mrp_checker u_mrp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_pos_x          (rsp_pos_x),
   .rsp_pos_y          (rsp_pos_y),
   .rsp_placed_width   (rsp_placed_width),
   .rsp_placed_height  (rsp_placed_height),
   .rsp_rotated        (rsp_rotated),
   .rsp_placed         (rsp_placed),
   .rsp_table_overflow (rsp_table_overflow)
);
`default_nettype wire
